@@ rtl/lpbd_pkg.sv @@
package lpbd_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int AGE_BITS_DEF = 16;
  localparam int ADDR_W       = 32;
  localparam int SLOT_W       = 3;

  localparam logic FN_GET     = 1'b0;
  localparam logic FN_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              load_page;
    logic              write_back;
    logic [ADDR_W-1:0] write_back_addr;
  } result_t;

endpackage

@@ rtl/lpbd_ram.sv @@
module lpbd_ram #(
  parameter int DEPTH = lpbd_pkg::SLOTS_DEF,
  parameter int WIDTH = lpbd_pkg::ADDR_W + lpbd_pkg::AGE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/lpbd_ctrl.sv @@
module lpbd_ctrl #(
  parameter int SLOTS    = lpbd_pkg::SLOTS_DEF,
  parameter int AGE_BITS = lpbd_pkg::AGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_accept,
  input  logic                                 func,
  input  logic [lpbd_pkg::ADDR_W-1:0]          page_addr,
  input  logic                                 out_free,
  output logic                                 busy,
  output logic                                 res_load,
  output lpbd_pkg::result_t                    res,
  output logic                                 rd_en,
  output logic [$clog2(SLOTS)-1:0]             rd_addr,
  input  logic [lpbd_pkg::ADDR_W+AGE_BITS-1:0] rd_data,
  output logic                                 wr_en,
  output logic [$clog2(SLOTS)-1:0]             wr_addr,
  output logic [lpbd_pkg::ADDR_W+AGE_BITS-1:0] wr_data
);

  localparam int IDX_W = $clog2(SLOTS);

  lpbd_pkg::state_t state, state_next;

  logic [IDX_W-1:0]            cnt;
  logic                        proc_vld;
  logic [IDX_W-1:0]            proc_idx;
  logic [SLOTS-1:0]            valid_q;
  logic                        op_get;
  logic [lpbd_pkg::ADDR_W-1:0] addr;
  logic                        hit_found;
  logic [IDX_W-1:0]            hit_idx;
  logic                        empty_found;
  logic [IDX_W-1:0]            empty_idx;
  logic [AGE_BITS-1:0]         best_age;
  logic [IDX_W-1:0]            max_idx;
  logic [lpbd_pkg::ADDR_W-1:0] best_tag;
  logic                        rel_any;

  logic [lpbd_pkg::ADDR_W-1:0] tag_j;
  logic [AGE_BITS-1:0]         age_j;
  logic [AGE_BITS-1:0]         aged;
  logic                        match;
  logic [IDX_W-1:0]            use_idx;
  logic                        evict;

  assign tag_j = rd_data[lpbd_pkg::ADDR_W+AGE_BITS-1:AGE_BITS];
  assign age_j = rd_data[AGE_BITS-1:0];
  assign aged  = (age_j == {AGE_BITS{1'b1}}) ? age_j : age_j + AGE_BITS'(1);
  assign match = valid_q[proc_idx] && (tag_j == addr);
  assign evict = !hit_found && !empty_found;

  always_comb begin
    priority if (hit_found) begin
      use_idx = hit_idx;
    end else if (empty_found) begin
      use_idx = empty_idx;
    end else begin
      use_idx = max_idx;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lpbd_pkg::ST_IDLE:   if (in_accept) state_next = lpbd_pkg::ST_SCAN;
      lpbd_pkg::ST_SCAN:   if (cnt == IDX_W'(SLOTS - 1)) state_next = lpbd_pkg::ST_TAIL;
      lpbd_pkg::ST_TAIL:   state_next = lpbd_pkg::ST_COMMIT;
      lpbd_pkg::ST_COMMIT: if (out_free) state_next = lpbd_pkg::ST_IDLE;
      default:             state_next = lpbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != lpbd_pkg::ST_IDLE);
    rd_en    = (state == lpbd_pkg::ST_SCAN);
    rd_addr  = cnt;
    res_load = (state == lpbd_pkg::ST_COMMIT) && out_free;
    wr_en    = 1'b0;
    wr_addr  = proc_idx;
    wr_data  = {tag_j, aged};
    if (proc_vld && op_get) begin
      wr_en = 1'b1;
    end else if (res_load && op_get) begin
      wr_en   = 1'b1;
      wr_addr = use_idx;
      wr_data = {addr, {AGE_BITS{1'b0}}};
    end
  end

  always_comb begin
    if (op_get) begin
      res.slot            = lpbd_pkg::SLOT_W'(use_idx);
      res.hit             = hit_found;
      res.load_page       = !hit_found;
      res.write_back      = evict;
      res.write_back_addr = evict ? best_tag : '0;
    end else begin
      res.slot            = '0;
      res.hit             = 1'b0;
      res.load_page       = 1'b0;
      res.write_back      = rel_any;
      res.write_back_addr = rel_any ? addr : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpbd_pkg::ST_IDLE;
      cnt      <= '0;
      proc_vld <= 1'b0;
      valid_q  <= '0;
    end else begin
      state    <= state_next;
      proc_vld <= (state == lpbd_pkg::ST_SCAN);
      if (in_accept) begin
        cnt <= '0;
      end else if (state == lpbd_pkg::ST_SCAN) begin
        cnt <= cnt + IDX_W'(1);
      end
      if (proc_vld && !op_get && match) begin
        valid_q[proc_idx] <= 1'b0;
      end
      if (res_load && op_get) begin
        valid_q[use_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= cnt;
    if (in_accept) begin
      op_get      <= (func == lpbd_pkg::FN_GET);
      addr        <= page_addr;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      rel_any     <= 1'b0;
    end else if (proc_vld) begin
      if (op_get) begin
        if (match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= proc_idx;
        end
        if (!valid_q[proc_idx] && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= proc_idx;
        end
        if (proc_idx == '0 || aged > best_age) begin
          best_age <= aged;
          max_idx  <= proc_idx;
          best_tag <= tag_j;
        end
      end else if (match) begin
        rel_any <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/lru_page_buffer_directory.sv @@
// Each request sweeps the slots one per cycle through the tag/age memory's
// single read port; a new request is taken only once the previous result has
// been moved into the output register.
// A new request is taken while the previous result still waits at the output.
// Reset clears the slot valid bits and the control state; tag and age memory
// contents need no clearing.
module lru_page_buffer_directory #(
  parameter int SLOTS    = lpbd_pkg::SLOTS_DEF,
  parameter int AGE_BITS = lpbd_pkg::AGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [lpbd_pkg::ADDR_W-1:0]       page_addr,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lpbd_pkg::SLOT_W-1:0]       slot,
  output logic                              hit,
  output logic                              load_page,
  output logic                              write_back,
  output logic [lpbd_pkg::ADDR_W-1:0]       write_back_addr
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int MEM_W = lpbd_pkg::ADDR_W + AGE_BITS;

  logic              busy;
  logic              in_accept;
  logic              out_free;
  logic              res_load;
  lpbd_pkg::result_t res;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [MEM_W-1:0]  rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [MEM_W-1:0]  wr_data;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign out_free  = !out_valid || !out_stall;

  lpbd_ctrl #(
    .SLOTS    (SLOTS),
    .AGE_BITS (AGE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .func      (func),
    .page_addr (page_addr),
    .out_free  (out_free),
    .busy      (busy),
    .res_load  (res_load),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  lpbd_ram #(
    .DEPTH (SLOTS),
    .WIDTH (MEM_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      slot            <= res.slot;
      hit             <= res.hit;
      load_page       <= res.load_page;
      write_back      <= res.write_back;
      write_back_addr <= res.write_back_addr;
    end
  end

  a_accept_no_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !res_load)
    else $error("result produced right after request transfer");

  a_hit_no_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (!load_page && !write_back))
    else $error("hit result asks for load or write-back");

  a_wb_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_back) |-> (write_back_addr == '0))
    else $error("write-back address set without write-back");

  a_load_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !res_load)
    else $error("result loaded over a stalled output");

endmodule
